[sv/cfv_pkg.sv]
// shared types, header layout constants and identifier table for the container file validator
package cfv_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned ByteW  = 8;

  localparam logic [CountW-1:0] HDR_LEN   = 32'd69;
  localparam logic [CountW-1:0] SIZE_AT   = 32'd5;
  localparam logic [CountW-1:0] SUM_AT    = 32'd65;
  localparam logic [CountW-1:0] IDENT_LEN = 32'd4;
  localparam logic [CountW-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FAIL_NONE  = 3'd0,
    FAIL_SHORT = 3'd1,
    FAIL_IDENT = 3'd2,
    FAIL_SIZE  = 3'd3,
    FAIL_SUM   = 3'd4
  } fail_reason_t;

  typedef struct packed {
    logic         is_valid;
    fail_reason_t fail_reason;
  } verdict_t;

  function automatic logic [ByteW-1:0] ident_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    unique case (idx)
      2'd0:    b = 8'h55;
      2'd1:    b = 8'h4E;
      2'd2:    b = 8'h46;
      default: b = 8'h45;
    endcase
    return b;
  endfunction

endpackage

[sv/cfv_accum.sv]
// per-file state: byte count, running sum, header fields and the end-of-file verdict
module cfv_accum
  import cfv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last,
  output verdict_t         verdict
);

  logic [CountW-1:0] count;
  logic [CountW-1:0] running_sum;
  logic [CountW-1:0] size_field;
  logic [CountW-1:0] stored_sum;
  logic              ident_ok;

  logic [CountW-1:0] count_next;
  logic [CountW-1:0] running_sum_next;
  logic [CountW-1:0] size_field_next;
  logic [CountW-1:0] stored_sum_next;
  logic              ident_ok_next;

  logic              in_ident;
  logic              in_size;
  logic              in_sum;
  logic [1:0]        lane;

  always_comb begin
    // both header words start at an offset of one mod four
    lane     = count[1:0] - 2'd1;
    in_ident = count < IDENT_LEN;
    in_size  = (count >= SIZE_AT) && (count < SIZE_AT + 32'd4);
    in_sum   = (count >= SUM_AT) && (count < SUM_AT + 32'd4);

    count_next = (count == COUNT_MAX) ? count : count + 32'd1;

    ident_ok_next = ident_ok & (~in_ident | (data_byte == ident_byte(count[1:0])));

    size_field_next = size_field;
    if (in_size) begin
      size_field_next[{lane, 3'b000} +: ByteW] = data_byte;
    end

    stored_sum_next  = stored_sum;
    running_sum_next = running_sum;
    if (in_sum) begin
      stored_sum_next[{lane, 3'b000} +: ByteW] = data_byte;
    end else begin
      running_sum_next = running_sum + {{(CountW-ByteW){1'b0}}, data_byte};
    end

    priority if (count_next < HDR_LEN) begin
      verdict.fail_reason = FAIL_SHORT;
    end else if (!ident_ok_next) begin
      verdict.fail_reason = FAIL_IDENT;
    end else if (size_field_next != count_next) begin
      verdict.fail_reason = FAIL_SIZE;
    end else if (stored_sum_next != running_sum_next) begin
      verdict.fail_reason = FAIL_SUM;
    end else begin
      verdict.fail_reason = FAIL_NONE;
    end
    verdict.is_valid = (verdict.fail_reason == FAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_sum <= '0;
      size_field  <= '0;
      stored_sum  <= '0;
      ident_ok    <= 1'b1;
    end else if (adv) begin
      if (last) begin
        count       <= '0;
        running_sum <= '0;
        size_field  <= '0;
        stored_sum  <= '0;
        ident_ok    <= 1'b1;
      end else begin
        count       <= count_next;
        running_sum <= running_sum_next;
        size_field  <= size_field_next;
        stored_sum  <= stored_sum_next;
        ident_ok    <= ident_ok_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (rst)
    adv && last |=> count == '0 && running_sum == '0 && ident_ok)
    else $error("state not cleared after final byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    adv && !last && count != COUNT_MAX |=> count == $past(count) + 32'd1)
    else $error("byte count did not advance");

  a_ident_sticky: assert property (@(posedge clk) disable iff (rst)
    !ident_ok && !(adv && last) |=> !ident_ok)
    else $error("identifier failure lost within a file");

  a_sum_frozen: assert property (@(posedge clk) disable iff (rst)
    adv && !last && in_sum |=> running_sum == $past(running_sum))
    else $error("checksum byte entered the running sum");
`endif

endmodule

[sv/cfv_out_reg.sv]
// result register holding one verdict until the downstream side takes it
module cfv_out_reg
  import cfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  verdict_t verdict,
  output logic     free,
  output logic     m_tvalid,
  input  logic     m_tready,
  output logic [7:0] m_tdata
);

  logic     out_valid;
  logic     out_valid_next;
  verdict_t result;

  assign free = ~out_valid | m_tready;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= verdict;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, result.fail_reason, result.is_valid};

endmodule

[sv/container_file_validator.sv]
// top level of the container file validator
// Takes a file one byte per item, the final byte marked by s_tlast, and gives one verdict
// item per file: is_valid and a failure reason (too short, identifier, size, checksum, checked
// in that order). Sustained rate is one byte per clock; a verdict passes from the input register
// holding its final byte into the result register behind it, which drives the output. The
// byte after a final byte starts a new file. Input is only held back while a verdict waits
// downstream and the registered byte is itself a final byte.
module container_file_validator
  import cfv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] is_valid, [3:1] fail_reason, [7:4] zero
);

  logic             in_valid;
  logic             in_valid_next;
  logic [ByteW-1:0] in_byte;
  logic             in_last;
  logic             out_free;
  logic             adv;
  logic             s_fire;
  verdict_t         verdict;

  assign adv      = in_valid & (~in_last | out_free);
  assign s_tready = ~in_valid | adv;
  assign s_fire   = s_tvalid & s_tready;

  always_comb begin
    in_valid_next = s_fire | (in_valid & ~adv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  cfv_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .data_byte (in_byte),
    .last      (in_last),
    .verdict   (verdict)
  );

  cfv_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (adv & in_last),
    .verdict  (verdict),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[dv/testbench.sv]
// testbench for the container file validator: directed and random files, verdicts checked
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfv_pkg::*;

  localparam logic [31:0] FILE_MAGIC = 32'h4546_4E55;
  localparam logic [2:0] FAULT_NONE  = 3'b000;
  localparam logic [2:0] FAULT_IDENT = 3'b001;
  localparam logic [2:0] FAULT_SIZE  = 3'b010;
  localparam logic [2:0] FAULT_SUM   = 3'b100;
  localparam int RANDOM_BYTES   = 1270;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAW} fill_t;

  typedef struct {
    int unsigned  len;
    fill_t        fill;
    logic [2:0]   faults;
    bit           pinned;
    fail_reason_t want;
  } file_row_t;

  typedef struct {
    bit           pinned;
    fail_reason_t want;
  } pin_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  bit         calm = 1'b0;
  int         mismatches = 0;
  int         stuck_cycles = 0;

  logic [7:0] file_bytes[$];
  pin_t       pins[$];
  verdict_t   verdicts[$];

  // predictor state
  logic [31:0] seen_count = '0;
  logic [31:0] byte_total = '0;
  logic [31:0] size_word = '0;
  logic [31:0] stored_word = '0;
  logic        magic_ok = 1'b1;

  container_file_validator DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  task automatic scan_byte(input logic [7:0] b, input logic fin);
    logic [31:0]  pos;
    logic [1:0]   lane;
    fail_reason_t why;
    verdict_t     v;
    pin_t         p;
    pos = seen_count;
    if (pos < IDENT_LEN && b != FILE_MAGIC[8*pos[1:0] +: 8]) magic_ok = 1'b0;
    if (pos >= SIZE_AT && pos < SIZE_AT + 4) begin
      lane = 2'(pos - SIZE_AT);
      size_word[8*lane +: 8] = b;
    end
    if (pos >= SUM_AT && pos < SUM_AT + 4) begin
      lane = 2'(pos - SUM_AT);
      stored_word[8*lane +: 8] = b;
    end else begin
      byte_total = byte_total + {24'd0, b};
    end
    if (seen_count != COUNT_MAX) seen_count = seen_count + 1;
    if (fin) begin
      if (seen_count < HDR_LEN) why = FAIL_SHORT;
      else if (!magic_ok) why = FAIL_IDENT;
      else if (size_word != seen_count) why = FAIL_SIZE;
      else if (stored_word != byte_total) why = FAIL_SUM;
      else why = FAIL_NONE;
      if (pins.size() != 0) begin
        p = pins.pop_front();
        if (p.pinned) why = p.want;
      end
      v.is_valid = (why == FAIL_NONE);
      v.fail_reason = why;
      verdicts.push_back(v);
      seen_count = '0;
      byte_total = '0;
      size_word = '0;
      stored_word = '0;
      magic_ok = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts.size() == 0) begin
        $error("verdict item with none expected: m_tdata %h", m_tdata);
        mismatches++;
      end else begin
        exp_v = verdicts.pop_front();
        if (m_tdata[0] !== exp_v.is_valid) begin
          $error("is_valid: expected %0d, actual %0d", exp_v.is_valid, m_tdata[0]);
          mismatches++;
        end
        if (m_tdata[3:1] !== exp_v.fail_reason) begin
          $error("fail_reason: expected %0d, actual %0d", exp_v.fail_reason, m_tdata[3:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic build_file(input file_row_t r);
    logic [31:0] hdr_size;
    logic [31:0] sum;
    logic [1:0]  bad_at;
    logic [7:0]  flip;
    file_bytes.delete();
    for (int i = 0; i < r.len; i++) begin
      case (r.fill)
        FILL_ZERO: file_bytes.push_back(8'h00);
        FILL_ONES: file_bytes.push_back(8'hFF);
        default:   file_bytes.push_back(8'($urandom));
      endcase
    end
    if (r.fill != FILL_RAW) begin
      hdr_size = r.len;
      if (r.faults & FAULT_SIZE) begin
        hdr_size = hdr_size + (($urandom_range(1) != 0) ? $urandom_range(1, 3) : ($urandom | 1));
      end
      bad_at = 2'($urandom_range(3));
      flip = 8'(1 << $urandom_range(7));
      for (int i = 0; i < 4; i++) begin
        if (i < r.len) begin
          file_bytes[i] = FILE_MAGIC[8*i +: 8];
          if ((r.faults & FAULT_IDENT) && i == bad_at) file_bytes[i] ^= flip;
        end
        if (SIZE_AT + i < r.len) file_bytes[SIZE_AT + i] = hdr_size[8*i +: 8];
      end
      sum = '0;
      for (int i = 0; i < r.len; i++) begin
        if (i < SUM_AT || i >= SUM_AT + 4) sum = sum + {24'd0, file_bytes[i]};
      end
      if (r.faults & FAULT_SUM) sum ^= 32'(1) << $urandom_range(31);
      for (int i = 0; i < 4; i++) begin
        if (SUM_AT + i < r.len) file_bytes[SUM_AT + i] = sum[8*i +: 8];
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_file(input file_row_t r);
    pin_t p;
    build_file(r);
    p.pinned = r.pinned;
    p.want = r.want;
    pins.push_back(p);
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  initial begin : stimulus
    file_row_t plan[$];
    file_row_t r;
    int        sent;
    int        file_no;
    int        pick;
    // after reset, extremes, each failure reason and the check order
    plan.push_back('{1, FILL_ONES, FAULT_NONE, 1'b1, FAIL_SHORT});
    plan.push_back('{68, FILL_ZERO, FAULT_NONE, 1'b1, FAIL_SHORT});
    plan.push_back('{40, FILL_RANDOM, FAULT_IDENT | FAULT_SIZE, 1'b1, FAIL_SHORT});
    plan.push_back('{69, FILL_ZERO, FAULT_NONE, 1'b1, FAIL_NONE});
    plan.push_back('{69, FILL_ONES, FAULT_NONE, 1'b1, FAIL_NONE});
    plan.push_back('{69, FILL_RANDOM, FAULT_IDENT, 1'b1, FAIL_IDENT});
    plan.push_back('{72, FILL_RANDOM, FAULT_IDENT | FAULT_SIZE | FAULT_SUM, 1'b1, FAIL_IDENT});
    plan.push_back('{70, FILL_RANDOM, FAULT_SIZE, 1'b1, FAIL_SIZE});
    plan.push_back('{71, FILL_ONES, FAULT_SIZE | FAULT_SUM, 1'b1, FAIL_SIZE});
    plan.push_back('{69, FILL_RANDOM, FAULT_SUM, 1'b1, FAIL_SUM});
    plan.push_back('{75, FILL_RANDOM, FAULT_NONE, 1'b0, FAIL_NONE});
    plan.push_back('{3, FILL_RAW, FAULT_NONE, 1'b0, FAIL_NONE});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_file(plan[i]);

    sent = 0;
    file_no = 0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      r.fill = FILL_RANDOM;
      r.faults = FAULT_NONE;
      r.pinned = 1'b0;
      r.want = FAIL_NONE;
      r.len = ($urandom_range(3) == 0) ? HDR_LEN : $urandom_range(HDR_LEN, 110);
      if ($urandom_range(39) == 0) r.len = $urandom_range(200, 400);
      if (pick < 8) begin
        r.len = $urandom_range(1, HDR_LEN - 1);
      end else if (pick < 14) begin
        r.fill = FILL_RAW;
        r.len = $urandom_range(1, 120);
      end else if (pick < 32) begin
        r.faults = 3'($urandom_range(1, 7));
      end
      calm = (file_no >= 8 && file_no < 14);
      send_file(r);
      sent += r.len;
      file_no++;
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    @(posedge clk);
    while (verdicts.size() != 0 || pins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[container_file_validator.f]
sv/cfv_pkg.sv
sv/cfv_accum.sv
sv/cfv_out_reg.sv
sv/container_file_validator.sv
dv/testbench.sv
